@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the one-wire bus master rtl
// expects clk and rst_n in scope at the point of use

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owbm assertion failed");

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owbm assertion failed");

`endif

@@ rtl/core/owbm_pkg.sv @@
// types and constants of the one-wire bus master
// no dependencies
`timescale 1ns / 1ps

package owbm_pkg;

    // timing register width and count
    localparam int REG_W    = 10;
    localparam int NUM_REGS = 7;

    // command codes
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_RESET      = 3'd1;
    localparam logic [2:0] CMD_WRITE_BIT  = 3'd2;
    localparam logic [2:0] CMD_READ_BIT   = 3'd3;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd4;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd5;

    // timing register indexes
    localparam logic [2:0] REG_START_PULSE   = 3'd0;
    localparam logic [2:0] REG_RESET_LOW     = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd2;
    localparam logic [2:0] REG_RESET_TAIL    = 3'd3;
    localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [2:0] REG_READ_TAIL     = 3'd6;

    // timing register reset values in microseconds
    localparam logic [REG_W-1:0] RST_START_PULSE   = 10'd1;
    localparam logic [REG_W-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [REG_W-1:0] RST_PRESENCE_WAIT = 10'd60;
    localparam logic [REG_W-1:0] RST_RESET_TAIL    = 10'd420;
    localparam logic [REG_W-1:0] RST_WRITE_SLOT    = 10'd60;
    localparam logic [REG_W-1:0] RST_READ_SAMPLE   = 10'd14;
    localparam logic [REG_W-1:0] RST_READ_TAIL     = 10'd45;

    // one tick with its optional command
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       line_level;
    } cmd_word_t;

    // one tick of bus drive and status
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_presence;
        logic       rejected;
    } res_word_t;

    // slot timings as written
    typedef struct packed {
        logic [REG_W-1:0] start_pulse_time;
        logic [REG_W-1:0] reset_low_time;
        logic [REG_W-1:0] presence_wait_time;
        logic [REG_W-1:0] reset_tail_time;
        logic [REG_W-1:0] write_slot_time;
        logic [REG_W-1:0] read_sample_time;
        logic [REG_W-1:0] read_tail_time;
    } timing_cfg_t;

endpackage

@@ rtl/core/owbm_cfg_regs.sv @@
// slot timing register file of the one-wire bus master
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_cfg_regs
    import owbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [REG_W-1:0] wr_data,
    output timing_cfg_t      timing
);

    timing_cfg_t timing_reg;
    timing_cfg_t timing_next;

    // decode the write, indexes past the list are dropped
    always_comb
    begin
        timing_next = timing_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_START_PULSE:   timing_next.start_pulse_time   = wr_data;
                REG_RESET_LOW:     timing_next.reset_low_time     = wr_data;
                REG_PRESENCE_WAIT: timing_next.presence_wait_time = wr_data;
                REG_RESET_TAIL:    timing_next.reset_tail_time    = wr_data;
                REG_WRITE_SLOT:    timing_next.write_slot_time    = wr_data;
                REG_READ_SAMPLE:   timing_next.read_sample_time   = wr_data;
                REG_READ_TAIL:     timing_next.read_tail_time     = wr_data;
                default:           timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.start_pulse_time   <= RST_START_PULSE;
            timing_reg.reset_low_time     <= RST_RESET_LOW;
            timing_reg.presence_wait_time <= RST_PRESENCE_WAIT;
            timing_reg.reset_tail_time    <= RST_RESET_TAIL;
            timing_reg.write_slot_time    <= RST_WRITE_SLOT;
            timing_reg.read_sample_time   <= RST_READ_SAMPLE;
            timing_reg.read_tail_time     <= RST_READ_TAIL;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule

@@ rtl/core/owbm_seq.sv @@
// slot sequencer of the one-wire bus master: phase, timer, bit and shift state
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_seq
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  cmd_word_t   cmd,
    input  timing_cfg_t timing,
    output res_word_t   res
);

    // phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_START = 4'd4;
    localparam logic [3:0] PH_WR_SLOT  = 4'd5;
    localparam logic [3:0] PH_RD_START = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_TAIL  = 4'd8;

    localparam int DW = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
    localparam logic [DW-1:0] TMAX_W = DW'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    // zero acts as one, values past the timer range are cut to it
    function automatic logic [TIMER_BITS-1:0] clamp_dur(input logic [REG_W-1:0] r);
        logic [DW-1:0] d;
        d = DW'(r);
        if (d == '0)
            d = DW'(1);
        if (d > TMAX_W)
            d = TMAX_W;
        return d[TIMER_BITS-1:0];
    endfunction

    logic [3:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tc_reg, tc_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  byte_reg, byte_next;
    logic                  pres_reg, pres_next;
    logic [7:0]            latch_reg, latch_next;

    logic                  cmd_ok;
    logic                  drive, busy, done, rej;
    logic [TIMER_BITS-1:0] dur;
    logic [TIMER_BITS-1:0] tc_inc;

    // one tick of the sequencer
    always_comb
    begin
        phase_next = phase_reg;
        tc_next    = tc_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        byte_next  = byte_reg;
        pres_next  = pres_reg;
        latch_next = latch_reg;
        drive      = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        dur        = clamp_dur(timing.start_pulse_time);
        tc_inc     = tc_reg;
        cmd_ok     = cmd.command inside {[CMD_RESET:CMD_READ_BYTE]};

        // command start or rejection
        if (phase_reg == PH_IDLE)
        begin
            if (cmd_ok)
            begin
                tc_next  = '0;
                bit_next = '0;
                case (cmd.command)
                    CMD_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    CMD_WRITE_BIT:
                    begin
                        byte_next  = 1'b0;
                        shift_next = {7'd0, cmd.data_byte[0]};
                        phase_next = PH_WR_START;
                    end
                    CMD_READ_BIT:
                    begin
                        byte_next  = 1'b0;
                        shift_next = '0;
                        phase_next = PH_RD_START;
                    end
                    CMD_WRITE_BYTE:
                    begin
                        byte_next  = 1'b1;
                        shift_next = cmd.data_byte;
                        phase_next = PH_WR_START;
                    end
                    default:
                    begin
                        byte_next  = 1'b1;
                        shift_next = '0;
                        phase_next = PH_RD_START;
                    end
                endcase
            end
        end
        else if (cmd_ok)
        begin
            rej = 1'b1;
        end

        // drive, duration and phase advance
        if (phase_next != PH_IDLE)
        begin
            busy = 1'b1;
            case (phase_next)
                PH_RST_LOW:  begin drive = 1'b1; dur = clamp_dur(timing.reset_low_time); end
                PH_RST_WAIT: begin drive = 1'b0; dur = clamp_dur(timing.presence_wait_time); end
                PH_RST_TAIL: begin drive = 1'b0; dur = clamp_dur(timing.reset_tail_time); end
                PH_WR_START: begin drive = 1'b1; dur = clamp_dur(timing.start_pulse_time); end
                PH_WR_SLOT:  begin drive = ~shift_next[0]; dur = clamp_dur(timing.write_slot_time); end
                PH_RD_START: begin drive = 1'b1; dur = clamp_dur(timing.start_pulse_time); end
                PH_RD_WAIT:  begin drive = 1'b0; dur = clamp_dur(timing.read_sample_time); end
                default:     begin drive = 1'b0; dur = clamp_dur(timing.read_tail_time); end
            endcase

            tc_inc = (tc_next < TMAX) ? tc_next + 1'b1 : tc_next;
            if (tc_inc >= dur)
            begin
                tc_next = '0;
                case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        pres_next  = cmd.line_level;
                        phase_next = PH_RST_TAIL;
                    end
                    PH_RST_TAIL:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WR_START: phase_next = PH_WR_SLOT;
                    PH_WR_SLOT:
                    begin
                        // next bit of a byte, or end of the write
                        if (byte_next && bit_next != 3'd7)
                        begin
                            bit_next   = bit_next + 3'd1;
                            shift_next = {1'b0, shift_next[7:1]};
                            phase_next = PH_WR_START;
                        end
                        else
                        begin
                            bit_next   = '0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_RD_START: phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        // sample the line, lsb first into a byte
                        if (byte_next)
                            shift_next = {cmd.line_level, shift_next[7:1]};
                        else
                            shift_next = {7'd0, cmd.line_level};
                        phase_next = PH_RD_TAIL;
                    end
                    default:
                    begin
                        // next bit of a byte, or end of the read
                        if (byte_next && bit_next != 3'd7)
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_RD_START;
                        end
                        else
                        begin
                            latch_next = shift_next;
                            bit_next   = '0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                endcase
            end
            else
            begin
                tc_next = tc_inc;
            end
        end
    end

    // sequencer state, updated once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tc_reg    <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            byte_reg  <= 1'b0;
            pres_reg  <= 1'b0;
            latch_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tc_reg    <= tc_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            byte_reg  <= byte_next;
            pres_reg  <= pres_next;
            latch_reg <= latch_next;
        end
    end

    // result of this tick
    always_comb
    begin
        res.drive_low   = drive;
        res.busy_res    = busy;
        res.done_res    = done;
        res.read_data   = latch_next;
        res.no_presence = pres_next;
        res.rejected    = rej;
    end

endmodule

@@ rtl/core/one_wire_bus_master_unit.sv @@
// top level of the one-wire bus master: input and result registers around the sequencer
// depends on owbm_pkg, owbm_cfg_regs, owbm_seq and assert_macros.svh
//
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_ready | cmd_word (command, data_byte, line_level)
//  res     | out       | res_valid / res_ready | res_word (drive, status, read data)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word per cycle unless the result register stalls: a tick lands in the input
// register, goes through the combinational sequencer logic and leaves from the result register
// rst_n clears the valid flags and sequencer state and loads the timing registers with their defaults
// a stalled result register holds the input register, which then drops cmd_ready
// cfg_ready is always high, a write takes effect on the next cycle
`timescale 1ns / 1ps

`include "assert_macros.svh"

module one_wire_bus_master_unit
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_word_t        cmd_word,
    output logic             res_valid,
    input  logic             res_ready,
    output res_word_t        res_word,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    cmd_word_t   in_word_reg;
    logic        out_valid_reg, out_valid_next;
    res_word_t   out_word_reg;
    logic        step;
    timing_cfg_t timing;
    res_word_t   seq_res;

    // timing registers
    assign cfg_ready = 1'b1;

    owbm_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timing   (timing)
    );

    // sequencer
    owbm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (in_word_reg),
        .timing (timing),
        .res    (seq_res)
    );

    // pipeline handshake
    assign step      = in_valid_reg && (!out_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_valid && cmd_ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            in_word_reg <= cmd_word;
        if (step)
            out_word_reg <= seq_res;
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // checks
    `OWBM_ASSERT_NOW(a_stall_only_on_full_out, !cmd_ready, res_valid && !res_ready)
    `OWBM_ASSERT_NOW(a_result_from_input, $rose(res_valid), $past(in_valid_reg))
    `OWBM_ASSERT_NOW(a_reject_while_busy, res_valid && res_word.rejected, res_word.busy_res)

endmodule

@@ tb/one_wire_bus_master_unit_tb.sv @@
// self-checking testbench of the one-wire bus master: per-tick prediction of drive and status
// depends on owbm_pkg and one_wire_bus_master_unit
`timescale 1ns / 1ps

module one_wire_bus_master_unit_tb;

    import owbm_pkg::*;

    localparam int TIMER_BITS = 10;
    localparam int unsigned TICK_MAX = (1 << TIMER_BITS) - 1;

    // codes the block must treat as no command
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // index past the register list, writes are dropped
    localparam logic [2:0] REG_OUT_OF_RANGE = 3'd7;

    // how the sampled line behaves during an operation
    localparam int LINE_LOW  = 0;
    localparam int LINE_HIGH = 1;
    localparam int LINE_RAND = 2;

    localparam int LONG_HOLD       = 64;
    localparam int TICKS_PER_PHASE = 230;

    // sequencer steps of the bus master
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_PRES_WAIT,
        SEQ_RST_TAIL,
        SEQ_WR_LOW,
        SEQ_WR_DATA,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_TAIL
    } seq_state_e;

    // tracks the bus master tick by tick and holds the words it must return
    class bus_tick_tracker;
        logic [REG_W-1:0] slot_time [NUM_REGS];
        seq_state_e       state;
        int unsigned      tick_cnt;
        logic [2:0]       bit_pos;
        logic [7:0]       shreg;
        bit               byte_op;
        logic             presence_level;
        logic [7:0]       read_byte;
        res_word_t        pending_bus_words [$];
        int               n_errors;

        function new();
            slot_time[REG_START_PULSE]   = RST_START_PULSE;
            slot_time[REG_RESET_LOW]     = RST_RESET_LOW;
            slot_time[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
            slot_time[REG_RESET_TAIL]    = RST_RESET_TAIL;
            slot_time[REG_WRITE_SLOT]    = RST_WRITE_SLOT;
            slot_time[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
            slot_time[REG_READ_TAIL]     = RST_READ_TAIL;
            state          = SEQ_IDLE;
            tick_cnt       = 0;
            bit_pos        = '0;
            shreg          = '0;
            byte_op        = 1'b0;
            presence_level = 1'b0;
            read_byte      = '0;
            n_errors       = 0;
        endfunction

        function void set_timing(logic [2:0] idx, logic [REG_W-1:0] value);
            if (idx < NUM_REGS)
                slot_time[idx] = value;
        endfunction

        function bit busy();
            return state != SEQ_IDLE;
        endfunction

        function int pending();
            return pending_bus_words.size();
        endfunction

        // zero counts as one tick, long counts stop at the timer range
        function int unsigned slot_len(logic [2:0] idx);
            int unsigned d;
            d = slot_time[idx];
            if (d == 0)
                d = 1;
            if (d > TICK_MAX)
                d = TICK_MAX;
            return d;
        endfunction

        // end of the data part of a slot, returns 1 when the operation completes
        function bit end_bit(bit wr);
            if (byte_op && bit_pos < 3'd7)
            begin
                bit_pos = bit_pos + 3'd1;
                if (wr)
                    shreg = shreg >> 1;
                state = wr ? SEQ_WR_LOW : SEQ_RD_LOW;
                return 1'b0;
            end
            if (!wr)
                read_byte = shreg;
            bit_pos = '0;
            state   = SEQ_IDLE;
            return 1'b1;
        endfunction

        // one accepted tick: advance the sequencer and queue the word it yields
        function void note_tick(cmd_word_t w);
            res_word_t   r;
            bit          is_cmd;
            int unsigned len;
            r      = '0;
            len    = 1;
            is_cmd = (w.command >= CMD_RESET) && (w.command <= CMD_READ_BYTE);

            // start on the accepting tick, or flag a command while busy
            if (state == SEQ_IDLE)
            begin
                if (is_cmd)
                begin
                    tick_cnt = 0;
                    bit_pos  = '0;
                    case (w.command)
                        CMD_RESET:
                            state = SEQ_RST_LOW;
                        CMD_WRITE_BIT:
                        begin
                            byte_op = 1'b0;
                            shreg   = {7'd0, w.data_byte[0]};
                            state   = SEQ_WR_LOW;
                        end
                        CMD_READ_BIT:
                        begin
                            byte_op = 1'b0;
                            shreg   = '0;
                            state   = SEQ_RD_LOW;
                        end
                        CMD_WRITE_BYTE:
                        begin
                            byte_op = 1'b1;
                            shreg   = w.data_byte;
                            state   = SEQ_WR_LOW;
                        end
                        default:
                        begin
                            byte_op = 1'b1;
                            shreg   = '0;
                            state   = SEQ_RD_LOW;
                        end
                    endcase
                end
            end
            else if (is_cmd)
                r.rejected = 1'b1;

            // drive and slot length of the current step
            if (state != SEQ_IDLE)
            begin
                r.busy_res = 1'b1;
                case (state)
                    SEQ_RST_LOW:
                    begin
                        r.drive_low = 1'b1;
                        len = slot_len(REG_RESET_LOW);
                    end
                    SEQ_PRES_WAIT:
                        len = slot_len(REG_PRESENCE_WAIT);
                    SEQ_RST_TAIL:
                        len = slot_len(REG_RESET_TAIL);
                    SEQ_WR_LOW:
                    begin
                        r.drive_low = 1'b1;
                        len = slot_len(REG_START_PULSE);
                    end
                    SEQ_WR_DATA:
                    begin
                        r.drive_low = !shreg[0];
                        len = slot_len(REG_WRITE_SLOT);
                    end
                    SEQ_RD_LOW:
                    begin
                        r.drive_low = 1'b1;
                        len = slot_len(REG_START_PULSE);
                    end
                    SEQ_RD_WAIT:
                        len = slot_len(REG_READ_SAMPLE);
                    default:
                        len = slot_len(REG_READ_TAIL);
                endcase

                // step ends, samples take the line of this tick
                if (tick_cnt < TICK_MAX)
                    tick_cnt++;
                if (tick_cnt >= len)
                begin
                    tick_cnt = 0;
                    case (state)
                        SEQ_RST_LOW:
                            state = SEQ_PRES_WAIT;
                        SEQ_PRES_WAIT:
                        begin
                            presence_level = w.line_level;
                            state = SEQ_RST_TAIL;
                        end
                        SEQ_RST_TAIL:
                        begin
                            state = SEQ_IDLE;
                            r.done_res = 1'b1;
                        end
                        SEQ_WR_LOW:
                            state = SEQ_WR_DATA;
                        SEQ_WR_DATA:
                            r.done_res = end_bit(1'b1);
                        SEQ_RD_LOW:
                            state = SEQ_RD_WAIT;
                        SEQ_RD_WAIT:
                        begin
                            shreg = byte_op ? {w.line_level, shreg[7:1]} : {7'd0, w.line_level};
                            state = SEQ_RD_TAIL;
                        end
                        default:
                            r.done_res = end_bit(1'b0);
                    endcase
                end
            end

            r.read_data   = read_byte;
            r.no_presence = presence_level;
            pending_bus_words.push_back(r);
        endfunction

        task report(string what);
            // cap the log, every mismatch still counts
            if (n_errors < 100)
                $display("%0t ns mismatch: %s", $time, what);
            n_errors++;
        endtask

        // compare a returned word with the oldest one owed
        task check_bus_word(res_word_t got);
            res_word_t want;
            if (pending_bus_words.size() == 0)
            begin
                report("result word with nothing owed");
                return;
            end
            want = pending_bus_words.pop_front();
            if (got.drive_low !== want.drive_low)
                report($sformatf("drive_low %b, want %b", got.drive_low, want.drive_low));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
            if (got.no_presence !== want.no_presence)
                report($sformatf("no_presence %b, want %b", got.no_presence, want.no_presence));
            if (got.rejected !== want.rejected)
                report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_word_t        cmd_word;
    logic             res_valid;
    logic             res_ready;
    res_word_t        res_word;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [2:0]       cfg_index;
    logic [REG_W-1:0] cfg_data;

    bus_tick_tracker tracker;
    bit              tx_quiet;
    bit              rx_quiet;
    bit              rx_hold_req;

    one_wire_bus_master_unit #(
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, a long hold on request
    initial
    begin : rx_side
        int stall_left;
        int r;
        stall_left = 0;
        res_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!rx_quiet)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 17)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.check_bus_word(res_word);
    end

    function automatic logic pick_line(int mode);
        if (mode == LINE_RAND)
            return 1'($urandom_range(0, 1));
        return mode == LINE_HIGH;
    endfunction

    // random tick: mostly new commands when idle, mostly quiet ticks when busy
    function automatic cmd_word_t rand_word(bit seq_busy);
        cmd_word_t w;
        int        r;
        r            = $urandom_range(0, 99);
        w.data_byte  = 8'($urandom_range(0, 255));
        w.line_level = 1'($urandom_range(0, 1));
        if (!seq_busy)
            w.command = (r < 72) ? 3'($urandom_range(CMD_RESET, CMD_READ_BYTE)) :
                        (r < 82) ? ($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6) :
                        CMD_NONE;
        else
            w.command = (r < 6) ? 3'($urandom_range(CMD_RESET, CMD_READ_BYTE)) :
                        (r < 9) ? ($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6) :
                        CMD_NONE;
        return w;
    endfunction

    // offer one tick word and wait for it to be taken
    task automatic push_word(cmd_word_t w);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do @(posedge clk); while (!cmd_ready);
        tracker.note_tick(w);
    endtask

    task automatic sender_gap();
        int n;
        int r;
        n = 0;
        if (!tx_quiet)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                n = $urandom_range(10, 30);
            else if (r >= 70)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // quiet ticks until the sequencer is back to idle
    task automatic finish_op(int line_mode);
        cmd_word_t w;
        w.command   = CMD_NONE;
        w.data_byte = 8'($urandom_range(0, 255));
        while (tracker.busy())
        begin
            w.line_level = pick_line(line_mode);
            push_word(w);
            sender_gap();
        end
    endtask

    task automatic run_op(logic [2:0] cmd, logic [7:0] data, int line_mode);
        cmd_word_t w;
        w.command    = cmd;
        w.data_byte  = data;
        w.line_level = pick_line(line_mode);
        push_word(w);
        sender_gap();
        finish_op(line_mode);
    endtask

    // stop offering and wait until every owed word is back
    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [REG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_timing(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_timing(int lo, int hi);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(3'(i), REG_W'($urandom_range(lo, hi)));
    endtask

    // stimulus
    initial
    begin
        cmd_word_t w;
        int        hi;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd_word    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_START_PULSE;
        cfg_data    = '0;
        tx_quiet    = 1'b1;
        rx_quiet    = 1'b1;
        rx_hold_req = 1'b0;
        tracker     = new();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // default slot timings straight out of reset
        run_op(CMD_WRITE_BIT, 8'h00, LINE_RAND);
        run_op(CMD_READ_BIT, 8'h00, LINE_RAND);
        drain();

        // shortest slots, plus a write to a register that does not exist
        program_timing(1, 1);
        write_reg(REG_OUT_OF_RANGE, '1);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        run_op(CMD_RESET, 8'h00, LINE_HIGH);
        run_op(CMD_RESET, 8'h00, LINE_LOW);
        run_op(CMD_WRITE_BIT, 8'hFE, LINE_RAND);
        run_op(CMD_WRITE_BIT, 8'h01, LINE_RAND);
        run_op(CMD_READ_BIT, 8'h00, LINE_HIGH);
        run_op(CMD_READ_BIT, 8'h00, LINE_LOW);
        run_op(CMD_WRITE_BYTE, 8'h00, LINE_RAND);
        run_op(CMD_WRITE_BYTE, 8'hFF, LINE_RAND);
        run_op(CMD_READ_BYTE, 8'h00, LINE_HIGH);
        run_op(CMD_READ_BYTE, 8'h00, LINE_RAND);
        run_op(CMD_SPARE_6, 8'hFF, LINE_RAND);
        run_op(CMD_SPARE_7, 8'hFF, LINE_RAND);

        // command on the completing tick of a write bit is turned away
        w = '{command: CMD_WRITE_BIT, data_byte: 8'h00, line_level: 1'b1};
        push_word(w);
        w.command = CMD_READ_BIT;
        push_word(w);

        // command in the middle of a reset is turned away
        w.command = CMD_RESET;
        push_word(w);
        w.command = CMD_WRITE_BYTE;
        push_word(w);
        finish_op(LINE_RAND);
        drain();

        // random traffic under several short slot settings, zero counts included
        for (int ph = 0; ph < 5; ph++)
        begin
            hi = $urandom_range(2, 16);
            program_timing(0, hi);
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 3);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                // result side holds off while ticks keep coming
                if (ph == 1 && n == 100)
                    rx_hold_req = 1'b1;
                // sender waits for every owed word mid-stream
                if (ph == 2 && n == 140)
                    drain();
                push_word(rand_word(tracker.busy()));
                sender_gap();
            end
            finish_op(LINE_RAND);
            drain();
        end

        repeat (10) @(posedge clk);
        if (tracker.n_errors == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/owbm_pkg.sv
rtl/core/owbm_cfg_regs.sv
rtl/core/owbm_seq.sv
rtl/core/one_wire_bus_master_unit.sv
tb/one_wire_bus_master_unit_tb.sv
